>>> rtl/core/button_debounce_press_hold_macros.svh
// assertion macros shared by the checker
`ifndef BUTTON_DEBOUNCE_PRESS_HOLD_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_HOLD_MACROS_SVH

// same-cycle implication, off while in reset
`define BDPH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define BDPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bdph_pkg.sv
package bdph_pkg;

    // field widths
    localparam int NOW_W   = 32;
    localparam int RAW_W   = 3;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 2;
    localparam int DEB_W   = 10;
    localparam int HOLD_W  = 16;
    localparam int CFG_D_W = 16;
    localparam int CFG_A_W = 1;

    // default button count
    localparam int NUM_BUTTONS_DEF = 3;

    // reset values of the timing registers
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(30);
    localparam logic [HOLD_W-1:0] HOLD_RST     = HOLD_W'(2000);

    // register indexes
    localparam logic [CFG_A_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_HOLD     = 1'b1;

    // event codes
    localparam logic [KIND_W-1:0] EV_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] EV_SHORT = 2'd1;
    localparam logic [KIND_W-1:0] EV_HOLD  = 2'd2;

    // event passed along the cell row
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
    } t_evt;

    // timing settings seen by every cell
    typedef struct packed {
        logic [DEB_W-1:0]  debounce_time;
        logic [HOLD_W-1:0] hold_time;
    } t_cfg;

endpackage

>>> rtl/core/bdph_poll_if.sv
interface bdph_poll_if;
    logic                        valid;
    logic                        ready;
    logic [bdph_pkg::NOW_W-1:0]  now_ms;
    logic [bdph_pkg::RAW_W-1:0]  raw_levels;

    modport source (output valid, now_ms, raw_levels, input ready);
    modport sink   (input valid, now_ms, raw_levels, output ready);
endinterface

>>> rtl/core/bdph_evt_if.sv
interface bdph_evt_if;
    logic                        valid;
    logic                        ready;
    logic [bdph_pkg::KIND_W-1:0] event_kind;
    logic [bdph_pkg::IDX_W-1:0]  button_index;

    modport source (output valid, event_kind, button_index, input ready);
    modport sink   (input valid, event_kind, button_index, output ready);
endinterface

>>> rtl/core/bdph_cell.sv
module bdph_cell #(
    parameter int IDX = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [bdph_pkg::NOW_W-1:0] i_now,
    input  logic                       i_raw,
    input  bdph_pkg::t_cfg             i_cfg,
    input  bdph_pkg::t_evt             i_evt,
    output bdph_pkg::t_evt             o_evt
);

    localparam logic [bdph_pkg::IDX_W-1:0] IDX_CODE = bdph_pkg::IDX_W'(IDX);

    logic                       r_stable;
    logic                       r_last_raw;
    logic [bdph_pkg::NOW_W-1:0] r_change_time;
    logic                       r_pressed;
    logic                       r_hold_done;
    logic [bdph_pkg::NOW_W-1:0] r_press_time;

    logic                       n_pressed;
    logic                       n_hold_done;
    logic [bdph_pkg::NOW_W-1:0] n_change_time;
    logic [bdph_pkg::NOW_W-1:0] n_press_time;

    logic stop_in;
    logic deb_ok;
    logic flip;
    logic press;
    logic release_ev;
    logic short_ev;
    logic hold_ev;
    logic hold_ok;

    assign stop_in = (i_evt.kind != bdph_pkg::EV_NONE);

    // debounce: a fresh raw change restarts the timer at this poll
    assign n_change_time = (i_raw != r_last_raw) ? i_now : r_change_time;
    assign deb_ok = (i_now - n_change_time) >= {{(bdph_pkg::NOW_W-bdph_pkg::DEB_W){1'b0}},
                                                 i_cfg.debounce_time};
    assign flip       = deb_ok && (i_raw != r_stable);
    assign press      = flip && !i_raw;
    assign release_ev = flip && i_raw;
    assign short_ev   = release_ev && r_pressed && !r_hold_done;

    // press bookkeeping after the stable transition
    assign n_pressed    = press ? 1'b1 : (release_ev ? 1'b0 : r_pressed);
    assign n_hold_done  = press ? 1'b0 : r_hold_done;
    assign n_press_time = press ? i_now : r_press_time;

    // hold check; a press in this poll has zero elapsed time
    assign hold_ok = (press ? (i_cfg.hold_time == '0)
                            : ((i_now - r_press_time) >=
                               {{(bdph_pkg::NOW_W-bdph_pkg::HOLD_W){1'b0}}, i_cfg.hold_time}));
    assign hold_ev = !short_ev && n_pressed && !n_hold_done && hold_ok;

    // first event wins, later cells pass it on
    always_comb begin
        o_evt = i_evt;
        if (!stop_in) begin
            if (short_ev) begin
                o_evt.kind = bdph_pkg::EV_SHORT;
                o_evt.idx  = IDX_CODE;
            end else if (hold_ev) begin
                o_evt.kind = bdph_pkg::EV_HOLD;
                o_evt.idx  = IDX_CODE;
            end
        end
    end

    // button state, touched only when no earlier cell stopped the poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable      <= 1'b1;
            r_last_raw    <= 1'b1;
            r_change_time <= '0;
            r_pressed     <= 1'b0;
            r_hold_done   <= 1'b0;
            r_press_time  <= '0;
        end else if (i_en && !stop_in) begin
            r_last_raw    <= i_raw;
            r_change_time <= n_change_time;
            r_stable      <= flip ? i_raw : r_stable;
            r_pressed     <= n_pressed;
            r_hold_done   <= hold_ev ? 1'b1 : n_hold_done;
            r_press_time  <= n_press_time;
        end
    end

endmodule

>>> rtl/core/button_debounce_press_hold.sv
// Debounced press and hold detector for a row of active-low buttons.
// Poll channel (i_poll): one item per poll, a millisecond timestamp and the
// raw pin levels, bit i for button i (1 released, 0 pressed).
// Event channel (o_evt): exactly one item per poll, event_kind none, short
// press or hold, and the button index (0 when there is no event).
// Config port: i_cfg_we writes i_cfg_data to reg i_cfg_idx (0 debounce time,
// 1 hold time); user must write only while no poll is in flight (not enforced).
// Each button is one cell in a row; a poll ripples combinationally through the
// row in index order and the first event stops later cells.
// Output: the registered event item is valid the cycle after the poll is accepted.
// Throughput: one poll per cycle unless o_evt.ready is low, set by the
// combinational pass through the cell row into the output register.
// Stall: the output register holds its item while o_evt.ready is low, and a
// new poll is taken in the same cycle the held item leaves.
// Reset: synchronous, active low; all buttons released, timers at zero,
// times back to 30 ms debounce and 2000 ms hold, no poll taken during reset.
module button_debounce_press_hold #(
    parameter int NUM_BUTTONS = bdph_pkg::NUM_BUTTONS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bdph_poll_if.sink                      i_poll,
    bdph_evt_if.source                     o_evt,
    input  logic                           i_cfg_we,
    input  logic [bdph_pkg::CFG_A_W-1:0]   i_cfg_idx,
    input  logic [bdph_pkg::CFG_D_W-1:0]   i_cfg_data
);

    bdph_pkg::t_cfg r_cfg;
    bdph_pkg::t_evt r_out_evt;
    logic           r_out_valid;
    logic           accept;

    bdph_pkg::t_evt chain [0:NUM_BUTTONS];

    // input taken when the output register is empty or draining
    assign i_poll.ready = i_rst_n && (!r_out_valid || o_evt.ready);
    assign accept       = i_poll.valid && i_poll.ready;

    // timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time <= bdph_pkg::DEBOUNCE_RST;
            r_cfg.hold_time     <= bdph_pkg::HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bdph_pkg::CFG_DEBOUNCE: r_cfg.debounce_time <= i_cfg_data[bdph_pkg::DEB_W-1:0];
                bdph_pkg::CFG_HOLD:     r_cfg.hold_time     <= i_cfg_data[bdph_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // cell row, head of the chain carries no event
    assign chain[0] = '{kind: bdph_pkg::EV_NONE, idx: '0};

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_cell
        logic raw;
        if (b < bdph_pkg::RAW_W) begin : g_pin
            assign raw = i_poll.raw_levels[b];
        end else begin : g_nopin
            // buttons without a pin read as pressed
            assign raw = 1'b0;
        end

        bdph_cell #(
            .IDX (b)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (accept),
            .i_now   (i_poll.now_ms),
            .i_raw   (raw),
            .i_cfg   (r_cfg),
            .i_evt   (chain[b]),
            .o_evt   (chain[b+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_evt <= chain[NUM_BUTTONS];
        end
    end

    assign o_evt.valid        = r_out_valid;
    assign o_evt.event_kind   = r_out_evt.kind;
    assign o_evt.button_index = r_out_evt.idx;

endmodule

>>> rtl/core/bdph_chk.sv
`include "button_debounce_press_hold_macros.svh"

module bdph_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [bdph_pkg::KIND_W-1:0]   i_kind,
    input logic [bdph_pkg::IDX_W-1:0]    i_idx
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // a stalled item stays put
    `BDPH_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind) && $stable(i_idx), "event item changed while stalled")
    // every poll yields an event item in the next cycle
    `BDPH_ASSERT_NEXT(a_poll_result, in_acc, i_out_valid, "poll gave no event item")
    // no item appears without a poll behind it
    `BDPH_ASSERT_NEXT(a_no_extra, out_acc && !in_acc, !i_out_valid, "event item without a poll")
    // no event means index zero
    `BDPH_ASSERT_NOW(a_idle_idx, i_out_valid && (i_kind == bdph_pkg::EV_NONE), i_idx == '0, "index set without an event")

endmodule

bind button_debounce_press_hold bdph_chk u_bdph_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_poll.valid),
    .i_in_ready  (i_poll.ready),
    .i_out_valid (o_evt.valid),
    .i_out_ready (o_evt.ready),
    .i_kind      (o_evt.event_kind),
    .i_idx       (o_evt.button_index)
);
